FILE: rtl/cfdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfdc_pkg: shared types and constants of the contact force drill controller
// Phase codes, sequencer states, multiply operation tags, register indexes
// and fixed widths of the datapath.
// ----------------------------------------------------------------------------
package cfdc_pkg;

  // Contact phase, as reported on the result port.
  typedef enum logic [1:0] {
    PH_FREE     = 2'd0,
    PH_APPROACH = 2'd1,
    PH_ACTIVE   = 2'd2,
    PH_RELEASE  = 2'd3
  } phase_e;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_POST   = 5'b01000,
    ST_FIN    = 5'b10000
  } state_e;

  // Which product the shared multiplier is working on.
  typedef enum logic [2:0] {
    OP_FREE = 3'd0,
    OP_APPR = 3'd1,
    OP_ACT1 = 3'd2,
    OP_ACT2 = 3'd3,
    OP_ACT3 = 3'd4
  } mul_op_e;

  // Register indexes on the configuration port (byte address is 8 * index).
  localparam logic [2:0] REG_APPROACH_GAIN   = 3'd0;
  localparam logic [2:0] REG_APPROACH_LIMIT  = 3'd1;
  localparam logic [2:0] REG_VELOCITY_GAIN   = 3'd2;
  localparam logic [2:0] REG_VELOCITY_LIMIT  = 3'd3;
  localparam logic [2:0] REG_FORCE_THRESHOLD = 3'd4;
  localparam logic [2:0] REG_START_VELOCITY  = 3'd5;

  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;
  localparam int unsigned GainW = 40;
  localparam int unsigned LimW  = 31;
  localparam int unsigned MulAW = 48;
  localparam int unsigned MulBW = 40;
  localparam int unsigned AccW  = 88;

  // Longest accepted tick interval, 0.5 s in units of 2^-16 s.
  localparam logic [15:0] HALF_SECOND = 16'd32768;

  // Register reset values.
  localparam logic [39:0] APPROACH_GAIN_RST   = 40'd28147498;
  localparam logic [30:0] APPROACH_LIMIT_RST  = 31'd53687091;
  localparam logic [39:0] VELOCITY_GAIN_RST   = 40'd281474977;
  localparam logic [30:0] VELOCITY_LIMIT_RST  = 31'd1073742;
  localparam logic [30:0] FORCE_THRESHOLD_RST = 31'd327680;
  localparam logic [31:0] START_VELOCITY_RST  = 32'd1073742;

endpackage
`default_nettype wire

FILE: rtl/contact_force_drill_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// contact_force_drill_controller_top: force-controlled drilling step per tick
// Four-phase contact machine with a shared byte-serial multiplier that forms
// the approach step, the force-driven velocity correction and the z step.
// ----------------------------------------------------------------------------
// One control word is taken at a time. A word with a tick interval of zero or
// above 0.5 s is dropped in its accept cycle and gives no result. Any other
// word occupies the block until its result enters the output register; the
// releasing phase forms no product, approaching and free one, active three.
// The occupancy is set by the single 48 x 8 multiply-accumulate unit, which
// takes one byte of its second operand per cycle (two bytes of the tick
// interval, five of a 40-bit operand), and by the three dependent products
// of the active phase. The result sits in an output register, so a new word
// is taken while the previous result still waits downstream.
// ----------------------------------------------------------------------------
module contact_force_drill_controller_top #(
  parameter int unsigned CONTACT_TICKS = 3
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // configuration port
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [cfdc_pkg::AddrW-1:0]   paddr,
  input  wire [cfdc_pkg::DataW-1:0]   pwdata,
  output logic [cfdc_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  // input words
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire signed [31:0]           measured_force_i,
  input  wire signed [31:0]           measured_velocity_i,
  input  wire signed [31:0]           target_force_i,
  input  wire signed [31:0]           current_z_i,
  input  wire [15:0]                  tick_interval_i,
  // result words
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic signed [31:0]          target_z_o,
  output logic                        go_home_o,
  output logic [1:0]                  contact_phase_o
);

  import cfdc_pkg::*;

  localparam int unsigned DbW = $clog2(CONTACT_TICKS + 1);

  // Configuration registers
  logic [GainW-1:0] approach_gain_q;
  logic [LimW-1:0]  approach_limit_q;
  logic [GainW-1:0] velocity_gain_q;
  logic [LimW-1:0]  velocity_limit_q;
  logic [LimW-1:0]  force_threshold_q;
  logic [31:0]      start_velocity_q;
  logic             cfg_we;

  // Sequencer and captured word
  state_e           state_q, state_d;
  mul_op_e          op_q, op_d;
  logic [31:0]      force_q, meas_v_q, target_q, cur_z_q;
  logic [15:0]      dt_q;
  logic             in_accept, dt_ok;

  // Controller state
  phase_e           phase_q, phase_d;
  logic [DbW-1:0]   deb_q, deb_d, deb_inc;
  logic [31:0]      cv_q, cv_d;

  // Shared multiplier
  logic [MulAW-1:0] mul_a_q, mul_a_d;
  logic [MulBW-1:0] mul_b_q, mul_b_d;
  logic [2:0]       dig_cnt_q, dig_cnt_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [55:0]      mul_prod;
  logic             neg_q, neg_d;
  logic [31:0]      res_z_q, res_z_d;

  // Output register
  logic             out_valid_q, out_valid_d, out_load;
  logic [31:0]      target_z_q;
  logic             go_home_q;
  phase_e           out_phase_q;

  // Decision and post-processing terms
  logic             above;
  logic [32:0]      thr_ext, e_free, mag_free, e_act, mag_act;
  logic [31:0]      cv_new;
  logic [32:0]      cv_ext, cv_mag;
  logic [53:0]      free_step_raw;
  logic [30:0]      free_step;
  logic [37:0]      m_raw;
  logic [30:0]      m_clamped;
  logic [31:0]      dv;
  logic [32:0]      lim_ext, neg_lim, nv_sum;
  logic [31:0]      nv;
  logic [33:0]      s_sum, s_mag;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      approach_gain_q   <= APPROACH_GAIN_RST;
      approach_limit_q  <= APPROACH_LIMIT_RST;
      velocity_gain_q   <= VELOCITY_GAIN_RST;
      velocity_limit_q  <= VELOCITY_LIMIT_RST;
      force_threshold_q <= FORCE_THRESHOLD_RST;
      start_velocity_q  <= START_VELOCITY_RST;
    end else if (cfg_we) begin
      case (paddr[5:3])
        REG_APPROACH_GAIN:   approach_gain_q   <= pwdata[GainW-1:0];
        REG_APPROACH_LIMIT:  approach_limit_q  <= pwdata[LimW-1:0];
        REG_VELOCITY_GAIN:   velocity_gain_q   <= pwdata[GainW-1:0];
        REG_VELOCITY_LIMIT:  velocity_limit_q  <= pwdata[LimW-1:0];
        REG_FORCE_THRESHOLD: force_threshold_q <= pwdata[LimW-1:0];
        REG_START_VELOCITY:  start_velocity_q  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_APPROACH_GAIN:   prdata = {24'd0, approach_gain_q};
      REG_APPROACH_LIMIT:  prdata = {33'd0, approach_limit_q};
      REG_VELOCITY_GAIN:   prdata = {24'd0, velocity_gain_q};
      REG_VELOCITY_LIMIT:  prdata = {33'd0, velocity_limit_q};
      REG_FORCE_THRESHOLD: prdata = {33'd0, force_threshold_q};
      REG_START_VELOCITY:  prdata = {32'd0, start_velocity_q};
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input handshake
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i & (state_q == ST_IDLE);
  assign dt_ok      = (tick_interval_i != 16'd0) && (tick_interval_i <= HALF_SECOND);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      force_q  <= measured_force_i;
      meas_v_q <= measured_velocity_i;
      target_q <= target_force_i;
      cur_z_q  <= current_z_i;
      dt_q     <= tick_interval_i;
    end
  end

  // --------------------------------------------------------------------------
  // Arithmetic terms
  // --------------------------------------------------------------------------
  assign thr_ext  = {2'b00, force_threshold_q};
  assign above    = $signed({force_q[31], force_q}) >= $signed(thr_ext);
  assign e_free   = {force_q[31], force_q} - thr_ext;
  assign mag_free = e_free[32] ? (33'd0 - e_free) : e_free;
  assign e_act    = {force_q[31], force_q} - {target_q[31], target_q};
  assign mag_act  = e_act[32] ? (33'd0 - e_act) : e_act;
  assign deb_inc  = deb_q + DbW'(1);

  // Velocity after the approaching-phase debounce update.
  always_comb begin
    cv_new = cv_q;
    if (above) begin
      if (deb_inc >= DbW'(CONTACT_TICKS)) begin
        cv_new = meas_v_q;
      end else if (deb_inc == DbW'(1)) begin
        cv_new = start_velocity_q;
      end
    end
  end
  assign cv_ext = {cv_new[31], cv_new};
  assign cv_mag = cv_new[31] ? (33'd0 - cv_ext) : cv_ext;

  // Byte-serial multiply, most significant byte of the second operand first.
  assign mul_prod = mul_a_q * mul_b_q[MulBW-1 -: 8];

  // Free phase: clamped approach step.
  assign free_step_raw = acc_q[AccW-1:34];
  assign free_step = (free_step_raw > {23'd0, approach_limit_q}) ?
                     approach_limit_q : free_step_raw[30:0];

  // Active phase: clamped velocity correction, new velocity and step operand.
  assign m_raw     = acc_q[AccW-1:50];
  assign m_clamped = (m_raw > {7'd0, velocity_limit_q}) ?
                     velocity_limit_q : m_raw[30:0];
  assign dv        = neg_q ? (32'd0 - {1'b0, m_clamped}) : {1'b0, m_clamped};
  assign lim_ext   = {2'b00, velocity_limit_q};
  assign neg_lim   = 33'd0 - lim_ext;
  assign nv_sum    = {cv_q[31], cv_q} + {dv[31], dv};
  always_comb begin
    if ($signed(nv_sum) > $signed(lim_ext)) begin
      nv = lim_ext[31:0];
    end else if ($signed(nv_sum) < $signed(neg_lim)) begin
      nv = neg_lim[31:0];
    end else begin
      nv = nv_sum[31:0];
    end
  end
  assign s_sum = {cv_q[31], cv_q, 1'b0} + {{2{dv[31]}}, dv};
  assign s_mag = s_sum[33] ? (34'd0 - s_sum) : s_sum;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    phase_d   = phase_q;
    deb_d     = deb_q;
    cv_d      = cv_q;
    mul_a_d   = mul_a_q;
    mul_b_d   = mul_b_q;
    dig_cnt_d = dig_cnt_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    res_z_d   = res_z_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept && dt_ok) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        acc_d = '0;
        case (phase_q)
          PH_FREE: begin
            if (above) begin
              if (deb_inc >= DbW'(CONTACT_TICKS)) begin
                phase_d = PH_APPROACH;
                deb_d   = '0;
              end else begin
                deb_d = deb_inc;
              end
            end else begin
              deb_d = '0;
            end
            mul_a_d   = {8'd0, approach_gain_q};
            mul_b_d   = {7'd0, mag_free};
            dig_cnt_d = 3'd4;
            op_d      = OP_FREE;
            state_d   = ST_MUL;
          end
          PH_APPROACH: begin
            if (above) begin
              if (deb_inc >= DbW'(CONTACT_TICKS)) begin
                phase_d = PH_ACTIVE;
                deb_d   = '0;
              end else begin
                deb_d = deb_inc;
              end
            end else begin
              deb_d   = '0;
              phase_d = PH_FREE;
            end
            cv_d      = cv_new;
            neg_d     = cv_new[31];
            mul_a_d   = {15'd0, cv_mag};
            mul_b_d   = {dt_q, 24'd0};
            dig_cnt_d = 3'd1;
            op_d      = OP_APPR;
            state_d   = ST_MUL;
          end
          PH_ACTIVE: begin
            if (!above) begin
              if (deb_inc >= DbW'(CONTACT_TICKS)) begin
                phase_d = PH_RELEASE;
                deb_d   = '0;
              end else begin
                deb_d = deb_inc;
              end
            end else begin
              deb_d = '0;
            end
            neg_d     = e_act[32];
            mul_a_d   = {15'd0, mag_act};
            mul_b_d   = {dt_q, 24'd0};
            dig_cnt_d = 3'd1;
            op_d      = OP_ACT1;
            state_d   = ST_MUL;
          end
          default: begin
            // Releasing: force back above threshold returns to active, no step.
            if (above) begin
              phase_d = PH_ACTIVE;
              deb_d   = '0;
            end
            res_z_d = cur_z_q;
            state_d = ST_FIN;
          end
        endcase
      end

      ST_MUL: begin
        acc_d   = {acc_q[AccW-9:0], 8'd0} + {32'd0, mul_prod};
        mul_b_d = {mul_b_q[MulBW-9:0], 8'd0};
        if (dig_cnt_q == 3'd0) begin
          state_d = ST_POST;
        end else begin
          dig_cnt_d = dig_cnt_q - 3'd1;
        end
      end

      ST_POST: begin
        case (op_q)
          OP_FREE: begin
            res_z_d = cur_z_q - {1'b0, free_step};
            state_d = ST_FIN;
          end
          OP_APPR: begin
            res_z_d = neg_q ? (cur_z_q + acc_q[47:16]) : (cur_z_q - acc_q[47:16]);
            state_d = ST_FIN;
          end
          OP_ACT1: begin
            // Error magnitude times interval, now scaled by the velocity gain.
            acc_d     = '0;
            mul_a_d   = acc_q[MulAW-1:0];
            mul_b_d   = velocity_gain_q;
            dig_cnt_d = 3'd4;
            op_d      = OP_ACT2;
            state_d   = ST_MUL;
          end
          OP_ACT2: begin
            // The step uses the old velocity, so it is formed before the update.
            cv_d      = nv;
            neg_d     = s_sum[33];
            acc_d     = '0;
            mul_a_d   = {14'd0, s_mag};
            mul_b_d   = {dt_q, 24'd0};
            dig_cnt_d = 3'd1;
            op_d      = OP_ACT3;
            state_d   = ST_MUL;
          end
          OP_ACT3: begin
            res_z_d = neg_q ? (cur_z_q - acc_q[48:17]) : (cur_z_q + acc_q[48:17]);
            state_d = ST_FIN;
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end

      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_FREE;
      phase_q <= PH_FREE;
      deb_q   <= '0;
      cv_q    <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      phase_q <= phase_d;
      deb_q   <= deb_d;
      cv_q    <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    dig_cnt_q <= dig_cnt_d;
    acc_q     <= acc_d;
    neg_q     <= neg_d;
    res_z_q   <= res_z_d;
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // A releasing result holds position and asks for the home pose.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      target_z_q  <= (phase_q == PH_RELEASE) ? cur_z_q : res_z_q;
      go_home_q   <= (phase_q == PH_RELEASE);
      out_phase_q <= phase_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign target_z_o      = target_z_q;
  assign go_home_o       = go_home_q;
  assign contact_phase_o = out_phase_q;

endmodule
`default_nettype wire
